// ----- rtl/drm_pkg.sv -----
// ----------------------------------------------------------------------------
// drm_pkg
// Shared constants and types of the diagonal relief mask core.
// ----------------------------------------------------------------------------
package drm_pkg;

   // Line store depth and the row span after which the row counter wraps.
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_SPAN  = 1024;
   localparam int ROW_W     = $clog2(ROW_SPAN);

   // Field and register widths.
   localparam int CHAN_W     = 8;
   localparam int DIM_W      = 11;
   localparam int THR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_THRESHOLD = 2'd2;

   // Register values after reset.
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd1024;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd1024;
   localparam logic [THR_W-1:0] THRESH_RESET = 8'd10;

   typedef enum logic [1:0] {
      CLASS_BG    = 2'd0,
      CLASS_DARK  = 2'd1,
      CLASS_LIGHT = 2'd2
   } class_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // One line store entry: the pixel and the class it was given.
   typedef struct packed {
      class_type cls;
      pixel_type pix;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [COL_W-1:0] addr;
      entry_type        data;
   } store_write_type;

endpackage

// ----- rtl/drm_line_store.sv -----
// ----------------------------------------------------------------------------
// drm_line_store
// One-row store of pixels and classes, one write and one registered read.
// ----------------------------------------------------------------------------
module drm_line_store
   import drm_pkg::*;
(
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output entry_type        rd_data,
   input  store_write_type  wr
);

   entry_type mem [MAX_WIDTH];
   entry_type rd_data_ff;

   // A read and a write to the same entry in one cycle return the old entry.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/diagonal_relief_mask_core.sv -----
// ----------------------------------------------------------------------------
// diagonal_relief_mask_core
// Classifies a raster stream of RGB pixels against their upper-left neighbors.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                               Direction  Moves
//   req      req_valid/req_stall, req_red,       in         one pixel
//            req_green, req_blue
//   rsp      rsp_valid/rsp_stall, rsp_mask_class out        one class
//   csr      csr_write, csr_index, csr_wdata     in         one register write
//
// One pixel transaction is taken in every clock cycle while req_stall is low;
// the class of a pixel leaves the output register after it passes the line
// store read, the compare stage and the class stage.
// Reset clears the position counters, the registers to their defaults, the
// diagonal entry and every valid bit; the line store is not cleared.
// A stall on rsp holds the output register while empty stages behind it keep
// filling, and req_stall rises only when all three stages hold a transaction
// and the output is stalled.
//
module diagonal_relief_mask_core
   import drm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_red,
   input  logic [CHAN_W-1:0]     req_green,
   input  logic [CHAN_W-1:0]     req_blue,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_mask_class,

   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Compare widths wide enough for a position plus one against a register.
   localparam int CCMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
   localparam int RCMP_W = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;

   // True when every channel of a exceeds the same channel of b by more than
   // the threshold.
   function automatic logic all_greater(pixel_type a, pixel_type b,
                                        logic [THR_W-1:0] thr);
      logic [CHAN_W:0] ra;
      logic [CHAN_W:0] gb;
      logic [CHAN_W:0] ba;
      ra = (CHAN_W+1)'(b.red)   + (CHAN_W+1)'(thr);
      gb = (CHAN_W+1)'(b.green) + (CHAN_W+1)'(thr);
      ba = (CHAN_W+1)'(b.blue)  + (CHAN_W+1)'(thr);
      return ((CHAN_W+1)'(a.red)   > ra) &&
             ((CHAN_W+1)'(a.green) > gb) &&
             ((CHAN_W+1)'(a.blue)  > ba);
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [DIM_W-1:0] width_ff,  width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [THR_W-1:0] thresh_ff, thresh_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      thresh_in = thresh_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:     width_in  = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:    height_in = csr_wdata[DIM_W-1:0];
            CSR_COLOR_THRESHOLD: thresh_in = csr_wdata[THR_W-1:0];
            default:             ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control. Each stage moves when the stage after it is
   // empty or moving itself.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_free, s1_free;
   logic req_accept, s1_go, s2_go;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_accept = req_valid && s1_free;
   assign s1_go      = s1_valid_ff && s2_free;
   assign s2_go      = s2_valid_ff && out_free;

   assign req_stall  = !s1_free;

   assign s1_valid_in  = req_accept ? 1'b1 : (s2_free ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s1_go ? 1'b1 : (out_free ? 1'b0 : s2_valid_ff);
   assign out_valid_in = s2_go ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);

   // ------------------------------------------------------------------------
   // Position counters, advanced with every accepted pixel. A width above the
   // store depth ends the row at the last entry, and a height above the row
   // span wraps at its end.
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             col_last, row_last;

   assign col_last = ((CCMP_W'(col_ff) + CCMP_W'(1)) >= CCMP_W'(width_ff)) ||
                     (col_ff == COL_W'(MAX_WIDTH - 1));
   assign row_last = ((RCMP_W'(row_ff) + RCMP_W'(1)) >= RCMP_W'(height_ff)) ||
                     (row_ff == ROW_W'(ROW_SPAN - 1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Line store. The entry at the pixel's column is read when the pixel is
   // taken. A write to that entry in the same cycle is caught by the bypass
   // register so that the first stage holds the newest entry as of that cycle.
   // ------------------------------------------------------------------------
   pixel_type       req_pix;
   store_write_type st_wr;
   entry_type       st_rd_data;

   assign req_pix.red   = req_red;
   assign req_pix.green = req_green;
   assign req_pix.blue  = req_blue;

   drm_line_store u_store (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (st_rd_data),
      .wr      (st_wr)
   );

   // ------------------------------------------------------------------------
   // Stage 1: pixel, its column, and the store entry of its column.
   // ------------------------------------------------------------------------
   pixel_type        s1_pix_ff, s1_pix_in;
   logic [COL_W-1:0] s1_col_ff, s1_col_in;
   logic             s1_inner_ff, s1_inner_in;
   logic             s1_byp_ff, s1_byp_in;
   entry_type        s1_byp_data_ff, s1_byp_data_in;
   entry_type        s1_entry;

   always_comb begin
      s1_pix_in      = s1_pix_ff;
      s1_col_in      = s1_col_ff;
      s1_inner_in    = s1_inner_ff;
      s1_byp_in      = s1_byp_ff;
      s1_byp_data_in = s1_byp_data_ff;
      if (req_accept) begin
         s1_pix_in      = req_pix;
         s1_col_in      = col_ff;
         s1_inner_in    = (col_ff != '0) && (row_ff != '0);
         s1_byp_in      = st_wr.en && (st_wr.addr == col_ff);
         s1_byp_data_in = st_wr.data;
      end
   end

   assign s1_entry = s1_byp_ff ? s1_byp_data_ff : st_rd_data;

   // The diagonal entry holds the old store entry of the previous pixel's
   // column, which is the upper-left neighbor of the pixel behind it. An
   // older pixel finishing its write while this one moves on is forwarded.
   entry_type diag_ff, diag_in;

   always_comb begin
      diag_in = diag_ff;
      if (s1_go) begin
         if (st_wr.en && (st_wr.addr == s1_col_ff)) begin
            diag_in = st_wr.data;
         end else begin
            diag_in = s1_entry;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: threshold compares in both directions against the neighbor.
   // ------------------------------------------------------------------------
   pixel_type        s2_pix_ff, s2_pix_in;
   logic [COL_W-1:0] s2_col_ff, s2_col_in;
   logic             s2_inner_ff, s2_inner_in;
   logic             s2_dark_ff, s2_dark_in;
   logic             s2_light_ff, s2_light_in;
   class_type        s2_up_cls_ff, s2_up_cls_in;
   class_type        s2_cls;

   always_comb begin
      s2_pix_in    = s2_pix_ff;
      s2_col_in    = s2_col_ff;
      s2_inner_in  = s2_inner_ff;
      s2_dark_in   = s2_dark_ff;
      s2_light_in  = s2_light_ff;
      s2_up_cls_in = s2_up_cls_ff;
      if (s1_go) begin
         s2_pix_in    = s1_pix_ff;
         s2_col_in    = s1_col_ff;
         s2_inner_in  = s1_inner_ff;
         s2_dark_in   = all_greater(diag_ff.pix, s1_pix_ff, thresh_ff);
         s2_light_in  = all_greater(s1_pix_ff, diag_ff.pix, thresh_ff);
         s2_up_cls_in = diag_ff.cls;
      end
   end

   // Dark wins over light; a dark neighbor carries its class down the
   // diagonal when neither compare holds. The first row and column stay
   // background.
   always_comb begin
      if (!s2_inner_ff) begin
         s2_cls = CLASS_BG;
      end else if (s2_dark_ff) begin
         s2_cls = CLASS_DARK;
      end else if (s2_light_ff) begin
         s2_cls = CLASS_LIGHT;
      end else if (s2_up_cls_ff == CLASS_DARK) begin
         s2_cls = CLASS_DARK;
      end else begin
         s2_cls = CLASS_BG;
      end
   end

   // The pixel and its class go back to the store as it leaves stage 2.
   assign st_wr.en       = s2_go;
   assign st_wr.addr     = s2_col_ff;
   assign st_wr.data.cls = s2_cls;
   assign st_wr.data.pix = s2_pix_ff;

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   class_type out_cls_ff, out_cls_in;

   assign out_cls_in = s2_go ? s2_cls : out_cls_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_mask_class = out_cls_ff;

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         thresh_ff    <= THRESH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         diag_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         thresh_ff    <= thresh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         diag_ff      <= diag_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pix_ff      <= s1_pix_in;
      s1_col_ff      <= s1_col_in;
      s1_inner_ff    <= s1_inner_in;
      s1_byp_ff      <= s1_byp_in;
      s1_byp_data_ff <= s1_byp_data_in;
      s2_pix_ff      <= s2_pix_in;
      s2_col_ff      <= s2_col_in;
      s2_inner_ff    <= s2_inner_in;
      s2_dark_ff     <= s2_dark_in;
      s2_light_ff    <= s2_light_in;
      s2_up_cls_ff   <= s2_up_cls_in;
      out_cls_ff     <= out_cls_in;
   end

endmodule

// ----- rtl/drm_checker.sv -----
// ----------------------------------------------------------------------------
// drm_checker
// Port-level checks of the diagonal relief mask core, bound to the top level.
// ----------------------------------------------------------------------------
module drm_checker
   import drm_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_mask_class
);

   logic req_take;

   assign req_take = req_valid && !req_stall;

   // Reset leaves the pipeline empty and ready.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mask_class)))
      else $error("stalled result changed");

   // A taken pixel reaches the output when the output is not stalled meanwhile.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_take ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing three cycles after the transaction");

   // With no results and no new pixels, the pipeline drains and opens.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !req_take) ##1 (!rsp_valid && !req_take) ##1 !rsp_valid
      |-> !req_stall)
      else $error("input stalled while the pipeline is empty");

endmodule

bind diagonal_relief_mask_core drm_checker u_drm_checker (.*);
